// ----- rtl/bas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bas_pkg - shared definitions for the bracket-aware splitter
// Byte codes, defaults, the parse-mode type and controller/datapath structs.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int MAX_DIGITS_DEF = 10;
    localparam int NEST_BITS_DEF  = 16;

    localparam logic [7:0] DELIM_RESET = 8'd44;   // ','
    localparam logic [7:0] CH_LBR      = 8'h5B;   // '['
    localparam logic [7:0] CH_RBR      = 8'h5D;   // ']'
    localparam logic [7:0] CH_0        = 8'h30;   // '0'
    localparam logic [7:0] CH_9        = 8'h39;   // '9'

    localparam int          LEN_W      = 31;
    localparam logic [30:0] LEN_MAX    = 31'h7FFF_FFFF;
    localparam logic [1:0]  SKIP_COUNT = 2'd2;

    localparam int          APB_AW     = 3;
    localparam logic        REG_DELIM  = 1'b0;   // register index of the delimiter

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_FIELD  = 3'b010,
        MODE_SKIP   = 3'b100
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_RELEASE = 4'b0010,
        S_MAIN    = 4'b0100,
        S_TAIL    = 4'b1000
    } t_state;

    // source of the next output item
    typedef enum logic [1:0] {
        SRC_FRESH = 2'd0,   // main item of the request being accepted now
        SRC_DIGIT = 2'd1,   // next held digit
        SRC_MAIN  = 2'd2,   // latched main item
        SRC_TAIL  = 2'd3    // closing end mark
    } t_src;

    typedef struct packed {
        logic accept;
        logic emit;
        t_src src;
        logic last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic new_rel;
        logic new_main;
        logic new_tail;
        logic p_main;
        logic p_tail;
        logic rel_last;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- rtl/bas_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bas_channels - valid/ready channels of the bracket-aware splitter
// Input channel carries one string byte, output channel one token item.
// ----------------------------------------------------------------------------
interface bas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface bas_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       token_end;
    logic       run_last;

    modport source (output valid, output out_byte, output token_end, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input token_end, input run_last,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/bracket_aware_splitter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_aware_splitter - top level of the bracket-aware token splitter
// Splits a byte string at the delimiter outside brackets, with counted fields.
// ----------------------------------------------------------------------------
// One string byte is taken per request on i_in and token bytes and end-of-token
// marks leave on o_out, run_last flagging the final item caused by a byte. A byte
// is taken when the sequencer is idle and the output register is free. A byte that
// releases no held digits sends its first item on the accepting edge, its own item
// if it has one and else the end mark that closes a final byte or a counted field.
// A byte that releases held digits (up to MAX_DIGITS) sends nothing on the
// accepting edge; the sequencer then sends each released digit, then the byte's
// own item and then the end mark. The input is held until the last of these items
// has entered the output register, and output stalls hold it longer.
// The single output register sends one item a cycle unless the output stalls, and
// the sequencer walks the held-digit buffer one entry per cycle under that condition.
// Digit runs are held back until they turn out to be ordinary text or a length
// prefix; the decimal length is accumulated as the digits arrive, saturating at
// 2^31-1. The delimiter register sits at APB address 0 and resets to ','.
// ----------------------------------------------------------------------------
module bracket_aware_splitter #(
    parameter int MAX_DIGITS = bas_pkg::MAX_DIGITS_DEF,
    parameter int NEST_BITS  = bas_pkg::NEST_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    bas_in_if.sink                      i_in,
    bas_out_if.source                   o_out,
    input  wire                         i_psel,
    input  wire                         i_penable,
    input  wire                         i_pwrite,
    input  wire [bas_pkg::APB_AW-1:0]   i_paddr,
    input  wire [31:0]                  i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);
    import bas_pkg::*;

    logic [7:0]  r_delim;
    t_ctrl_cmd   w_cmd;
    t_dp_status  w_status;
    logic        w_in_ready;

    // configuration: register index from address bit 2, word aligned
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_DELIM) ? {24'd0, r_delim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready &&
                     i_paddr[2] == REG_DELIM) begin
            r_delim <= i_pwdata[7:0];
        end
    end

    assign i_in.ready = w_in_ready;

    bas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    bas_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .NEST_BITS  (NEST_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_byte   (i_in.in_byte),
        .i_final     (i_in.final_byte),
        .i_delim     (r_delim),
        .i_out_ready (o_out.ready),
        .o_status    (w_status),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_end   (o_out.token_end),
        .o_out_last  (o_out.run_last)
    );

endmodule
`default_nettype wire

// ----- rtl/bas_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bas_ctrl - splitter sequencer
// Accepts a request, then walks released digits, main item and end mark.
// ----------------------------------------------------------------------------
module bas_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  bas_pkg::t_dp_status     i_status,
    output bas_pkg::t_ctrl_cmd      o_cmd,
    output logic                    o_in_ready
);
    import bas_pkg::*;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.src    = SRC_FRESH;
        o_cmd.last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.new_rel) begin
                        n_state = S_RELEASE;
                    end else if (i_status.new_main) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.src  = SRC_FRESH;
                        o_cmd.last = !i_status.new_tail;
                        n_state    = i_status.new_tail ? S_TAIL : S_IDLE;
                    end else if (i_status.new_tail) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.src  = SRC_TAIL;
                        o_cmd.last = 1'b1;
                    end
                end
            end
            S_RELEASE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_DIGIT;
                    o_cmd.last = i_status.rel_last && !i_status.p_main && !i_status.p_tail;
                    if (i_status.rel_last) begin
                        if (i_status.p_main) begin
                            n_state = S_MAIN;
                        end else if (i_status.p_tail) begin
                            n_state = S_TAIL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_MAIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_MAIN;
                    o_cmd.last = !i_status.p_tail;
                    n_state    = i_status.p_tail ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_TAIL;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("item emitted into a busy output register");

    a_release_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELEASE && n_state != S_RELEASE) |-> (o_cmd.emit && i_status.rel_last))
        else $error("release left before the last held digit");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after the final item of a request");

endmodule
`default_nettype wire

// ----- rtl/bas_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bas_datapath - splitter parse state, held digits and output register
// Decodes a byte into a plan (digits to release, main item, end mark).
// ----------------------------------------------------------------------------
module bas_datapath #(
    parameter int MAX_DIGITS = bas_pkg::MAX_DIGITS_DEF,
    parameter int NEST_BITS  = bas_pkg::NEST_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  bas_pkg::t_ctrl_cmd      i_cmd,
    input  wire [7:0]               i_in_byte,
    input  wire                     i_final,
    input  wire [7:0]               i_delim,
    input  wire                     i_out_ready,
    output bas_pkg::t_dp_status     o_status,
    output logic                    o_out_valid,
    output logic [7:0]              o_out_byte,
    output logic                    o_out_end,
    output logic                    o_out_last
);
    import bas_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // parse state
    logic [3:0]           r_held [MAX_DIGITS];
    logic [CNT_W-1:0]     r_held_count, n_held_count;
    logic [LEN_W-1:0]     r_acc, n_acc;
    logic [LEN_W-1:0]     r_field_len, n_field_len;
    logic [NEST_BITS-1:0] r_level, n_level;
    t_mode                r_mode, n_mode;
    logic [1:0]           r_skip, n_skip;
    logic                 r_started, n_started;
    logic                 r_donly, n_donly;

    // latched plan
    logic [CNT_W-1:0]     r_rel_cnt;
    logic [CNT_W-1:0]     r_rel_idx;
    logic                 r_p_main;
    logic                 r_p_end;
    logic [7:0]           r_p_byte;
    logic                 r_p_tail;

    // fresh plan for the byte on the input
    logic [CNT_W-1:0]     f_rel;
    logic                 f_main;
    logic                 f_end;
    logic                 f_tail;
    logic                 wr_held;

    logic                 is_digit;
    logic                 is_prefix;
    logic [3:0]           digit;
    logic [LEN_W+3:0]     acc_x10;
    logic [LEN_W-1:0]     acc_step;
    logic [LEN_W-1:0]     len_dec;
    logic [1:0]           skip_dec;

    logic                 e_end;
    logic [7:0]           e_byte;
    logic                 out_free;

    always_comb begin
        is_digit  = (i_in_byte inside {[CH_0:CH_9]});
        is_prefix = (i_in_byte == CH_LBR) && r_donly && (r_held_count != '0);
        digit     = i_in_byte[3:0];
        acc_x10   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (LEN_W+4)'(digit);
        acc_step  = (acc_x10 > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX : acc_x10[LEN_W-1:0];
        len_dec   = (r_field_len != '0) ? r_field_len - LEN_W'(1) : r_field_len;
        skip_dec  = (r_skip != 2'd0) ? r_skip - 2'd1 : r_skip;
    end

    // next state and plan of one byte
    always_comb begin
        n_held_count = r_held_count;
        n_acc        = r_acc;
        n_field_len  = r_field_len;
        n_level      = r_level;
        n_mode       = r_mode;
        n_skip       = r_skip;
        n_started    = r_started;
        n_donly      = r_donly;
        f_rel        = '0;
        f_main       = 1'b0;
        f_end        = 1'b0;
        f_tail       = 1'b0;
        wr_held      = 1'b0;
        case (r_mode)
            MODE_FIELD: begin
                f_main      = 1'b1;
                n_field_len = len_dec;
                if (len_dec == '0) begin
                    f_tail = 1'b1;
                    n_mode = MODE_SKIP;
                    n_skip = SKIP_COUNT;
                end else if (i_final) begin
                    f_tail = 1'b1;
                end
            end
            MODE_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 2'd0) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                if (is_prefix) begin
                    // digits were a length prefix: open a counted field, or close an empty one at once
                    n_held_count = '0;
                    n_started    = 1'b0;
                    n_donly      = 1'b1;
                    n_field_len  = r_acc;
                    if (r_acc == '0) begin
                        f_main = 1'b1;
                        f_end  = 1'b1;
                        n_mode = MODE_SKIP;
                        n_skip = SKIP_COUNT;
                    end else begin
                        n_mode = MODE_FIELD;
                        if (i_final) begin
                            f_main = 1'b1;
                            f_end  = 1'b1;
                        end
                    end
                end else begin
                    if (i_in_byte == CH_LBR) begin
                        n_level = r_level + NEST_BITS'(1);
                    end else if (i_in_byte == CH_RBR) begin
                        n_level = r_level - NEST_BITS'(1);
                    end
                    if (i_in_byte != CH_LBR && i_in_byte != CH_RBR &&
                        i_in_byte == i_delim && r_level == '0) begin
                        f_rel        = r_held_count;
                        n_held_count = '0;
                        f_main       = 1'b1;
                        f_end        = 1'b1;
                        n_started    = 1'b0;
                        n_donly      = 1'b1;
                    end else begin
                        n_started = 1'b1;
                        if (is_digit && r_donly && r_held_count < CNT_W'(MAX_DIGITS)) begin
                            wr_held      = 1'b1;
                            n_held_count = r_held_count + CNT_W'(1);
                            n_acc        = (r_held_count == '0) ? LEN_W'(digit) : acc_step;
                            if (i_final) begin
                                f_rel  = r_held_count + CNT_W'(1);
                                f_tail = 1'b1;
                            end
                        end else begin
                            f_rel        = r_held_count;
                            n_held_count = '0;
                            f_main       = 1'b1;
                            n_donly      = 1'b0;
                            f_tail       = i_final;
                        end
                    end
                end
            end
        endcase
        if (i_final) begin
            n_held_count = '0;
            n_field_len  = '0;
            n_level      = '0;
            n_mode       = MODE_NORMAL;
            n_skip       = 2'd0;
            n_started    = 1'b0;
            n_donly      = 1'b1;
        end
    end

    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        o_status.out_free = out_free;
        o_status.new_rel  = (f_rel != '0);
        o_status.new_main = f_main;
        o_status.new_tail = f_tail;
        o_status.p_main   = r_p_main;
        o_status.p_tail   = r_p_tail;
        o_status.rel_last = ((r_rel_idx + CNT_W'(1)) == r_rel_cnt);
    end

    // item selection
    always_comb begin
        case (i_cmd.src)
            SRC_FRESH: begin
                e_end  = f_end;
                e_byte = i_in_byte;
            end
            SRC_DIGIT: begin
                e_end  = 1'b0;
                e_byte = CH_0 + {4'b0, r_held[r_rel_idx[IDX_W-1:0]]};
            end
            SRC_MAIN: begin
                e_end  = r_p_end;
                e_byte = r_p_byte;
            end
            default: begin
                e_end  = 1'b1;
                e_byte = 8'd0;
            end
        endcase
    end

    // held digits: no reset, only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_held) begin
            r_held[r_held_count[IDX_W-1:0]] <= digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= '0;
            r_acc        <= '0;
            r_field_len  <= '0;
            r_level      <= '0;
            r_mode       <= MODE_NORMAL;
            r_skip       <= 2'd0;
            r_started    <= 1'b0;
            r_donly      <= 1'b1;
            r_rel_cnt    <= '0;
            r_rel_idx    <= '0;
            r_p_main     <= 1'b0;
            r_p_end      <= 1'b0;
            r_p_tail     <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_held_count <= n_held_count;
                r_acc        <= n_acc;
                r_field_len  <= n_field_len;
                r_level      <= n_level;
                r_mode       <= n_mode;
                r_skip       <= n_skip;
                r_started    <= n_started;
                r_donly      <= n_donly;
                r_rel_cnt    <= f_rel;
                r_rel_idx    <= '0;
                r_p_main     <= f_main;
                r_p_end      <= f_end;
                r_p_tail     <= f_tail;
            end else if (i_cmd.emit && i_cmd.src == SRC_DIGIT) begin
                r_rel_idx <= r_rel_idx + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_byte <= i_in_byte;
        end
        if (i_cmd.emit) begin
            o_out_end  <= e_end;
            o_out_byte <= e_end ? 8'd0 : e_byte;
            o_out_last <= i_cmd.last;
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count <= CNT_W'(MAX_DIGITS))
        else $error("held digit count beyond capacity");

    a_field_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FIELD) |-> (r_field_len != '0))
        else $error("counted field open with nothing owed");

endmodule
`default_nettype wire

// ----- sim/tb_bracket_aware_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_aware_splitter - self-checking bench for the bracket-aware splitter
// Feeds byte strings through the input channel with random gaps, drains token
// items with random stalls and compares each one against a cycle-free model of
// the splitter. The delimiter register is rewritten between phases over APB.
// ----------------------------------------------------------------------------
import bas_pkg::*;

typedef struct packed {
    logic [7:0] out_byte;
    logic       token_end;
    logic       run_last;
} t_token_item;

// Predicts the token items caused by every accepted byte and checks the
// items that leave the block against them, oldest first.
class token_checker;
    localparam int MAX_ITEMS = 12;

    logic [7:0]               delim;
    logic [3:0]               held [MAX_DIGITS_DEF];
    int                       held_cnt;
    logic [LEN_W-1:0]         field_left;
    logic [NEST_BITS_DEF-1:0] nest;
    t_mode                    mode;
    logic [1:0]               skip_left;
    bit                       started;
    bit                       only_digits;
    t_token_item              step_items[$];
    t_token_item              tokens_due[$];
    int                       errors;
    int                       n_bytes;
    int                       n_items;
    int                       n_ends;

    function new();
        delim   = DELIM_RESET;
        errors  = 0;
        n_bytes = 0;
        n_items = 0;
        n_ends  = 0;
        clear_parse();
    endfunction

    function void clear_parse();
        held_cnt    = 0;
        field_left  = '0;
        nest        = '0;
        mode        = MODE_NORMAL;
        skip_left   = '0;
        started     = 0;
        only_digits = 1;
    endfunction

    function void push_item(logic [7:0] data, logic is_end);
        t_token_item it;
        it.out_byte  = is_end ? 8'h00 : data;
        it.token_end = is_end;
        it.run_last  = 1'b0;
        if (step_items.size() < MAX_ITEMS)
            step_items.insert(step_items.size(), it);
    endfunction

    function void flush_digits();
        for (int k = 0; k < held_cnt; k++)
            push_item(CH_0 + 8'(held[k]), 1'b0);
        held_cnt = 0;
    endfunction

    function void end_token();
        push_item(8'h00, 1'b1);
        started     = 0;
        only_digits = 1;
    endfunction

    // one byte in normal splitting mode
    function void split_byte(logic [7:0] data);
        bit              is_dig;
        longint unsigned acc;
        is_dig = (data >= CH_0) && (data <= CH_9);
        // digits-only token followed by '[' is a length prefix
        if (data == CH_LBR && only_digits && held_cnt > 0) begin
            acc = 0;
            for (int k = 0; k < held_cnt; k++) begin
                acc = acc * 10 + held[k];
                if (acc > LEN_MAX)
                    acc = LEN_MAX;
            end
            held_cnt    = 0;
            started     = 0;
            only_digits = 1;
            field_left  = acc[LEN_W-1:0];
            if (field_left == 0) begin
                push_item(8'h00, 1'b1);
                mode      = MODE_SKIP;
                skip_left = SKIP_COUNT;
            end else begin
                mode = MODE_FIELD;
            end
            return;
        end
        // brackets win over the delimiter
        if (data == CH_LBR) begin
            nest = nest + 1'b1;
        end else if (data == CH_RBR) begin
            nest = nest - 1'b1;
        end else if (data == delim && nest == 0) begin
            flush_digits();
            end_token();
            return;
        end
        started = 1;
        if (is_dig && only_digits) begin
            if (held_cnt < MAX_DIGITS_DEF) begin
                held[held_cnt] = 4'(data - CH_0);
                held_cnt++;
                return;
            end
            // digit run too long for a prefix: plain text from here on
            flush_digits();
            push_item(data, 1'b0);
            only_digits = 0;
            return;
        end
        flush_digits();
        push_item(data, 1'b0);
        only_digits = 0;
    endfunction

    // accepted input request
    function void take_byte(logic [7:0] data, logic fin);
        n_bytes++;
        step_items.delete();
        case (mode)
            MODE_FIELD: begin
                push_item(data, 1'b0);
                if (field_left > 0)
                    field_left = field_left - 1'b1;
                if (field_left == 0) begin
                    push_item(8'h00, 1'b1);
                    mode      = MODE_SKIP;
                    skip_left = SKIP_COUNT;
                end else if (fin) begin
                    push_item(8'h00, 1'b1);
                end
            end
            MODE_SKIP: begin
                if (skip_left > 0)
                    skip_left = skip_left - 1'b1;
                if (skip_left == 0)
                    mode = MODE_NORMAL;
            end
            default: begin
                split_byte(data);
                if (fin) begin
                    if (mode == MODE_FIELD) begin
                        push_item(8'h00, 1'b1);
                    end else if (mode == MODE_NORMAL && started) begin
                        flush_digits();
                        end_token();
                    end
                end
            end
        endcase
        if (fin)
            clear_parse();
        if (step_items.size() > 0)
            step_items[step_items.size()-1].run_last = 1'b1;
        foreach (step_items[k])
            tokens_due.insert(tokens_due.size(), step_items[k]);
    endfunction

    function void note_error(string what, t_token_item want, t_token_item got);
        errors++;
        if (errors <= 10)
            $display("ERROR %0d: %s: expected byte %h end %b last %b, got byte %h end %b last %b",
                     errors, what, want.out_byte, want.token_end, want.run_last,
                     got.out_byte, got.token_end, got.run_last);
    endfunction

    // accepted output request
    function void match_item(t_token_item got);
        t_token_item want;
        n_items++;
        if (got.token_end === 1'b1)
            n_ends++;
        if (tokens_due.size() == 0) begin
            note_error("item with nothing expected", '0, got);
            return;
        end
        want = tokens_due.pop_front();
        if (got !== want)
            note_error("item mismatch", want, got);
    endfunction
endclass

module tb_bracket_aware_splitter;

    localparam int                CYCLE_LIMIT = 400000;
    localparam int                PHASE_ITEMS = 28;
    localparam int                QUIET_WAIT  = 20;
    localparam logic [APB_AW-1:0] DELIM_ADDR  = APB_AW'(4 * REG_DELIM);

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_byte_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [APB_AW-1:0] i_paddr;
    logic [31:0] i_pwdata;
    wire  [31:0] o_prdata;
    wire         o_pready;

    bas_in_if  in_ch ();
    bas_out_if out_ch ();

    bracket_aware_splitter u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    token_checker chk = new();

    t_byte_req   stim_q[$];
    logic [7:0]  cur_delim;
    int          cycles = 0;
    int          n_phases;
    bit          in_calm;
    bit          out_calm;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function void add_byte(logic [7:0] data, logic fin);
        t_byte_req req;
        req.data = data;
        req.fin  = fin;
        stim_q.insert(stim_q.size(), req);
    endfunction

    function void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k], 1'b0);
    endfunction

    function logic [7:0] rand_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // One random string of 1..5 tokens joined by the current delimiter.
    // Mostly well-formed tokens and length-prefixed fields, some noise.
    function void add_random_string();
        int n_tok;
        int len;
        bit ended;
        ended = 0;
        n_tok = $urandom_range(1, 5);
        for (int t = 0; t < n_tok && !ended; t++) begin
            if (t > 0)
                add_byte(cur_delim, 1'b0);
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    // plain text, sometimes with a bracket group holding a delimiter
                    len = $urandom_range(1, 5);
                    for (int k = 0; k < len; k++)
                        add_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(),
                                 1'b0);
                    if ($urandom_range(0, 2) == 0) begin
                        add_byte(CH_LBR, 1'b0);
                        add_byte(rand_letter(), 1'b0);
                        add_byte(cur_delim, 1'b0);
                        add_byte(rand_letter(), 1'b0);
                        add_byte(CH_RBR, 1'b0);
                    end
                end
                3: begin
                    // digit-only token, released at the next non-digit
                    len = $urandom_range(1, MAX_DIGITS_DEF);
                    for (int k = 0; k < len; k++)
                        add_byte(rand_digit(), 1'b0);
                    if ($urandom_range(0, 1) == 0)
                        add_byte(rand_letter(), 1'b0);
                end
                4, 5, 6: begin
                    // short counted field, then the two skipped bytes
                    len = $urandom_range(0, 6);
                    if ($urandom_range(0, 3) == 0)
                        add_byte(CH_0, 1'b0);
                    add_byte(CH_0 + 8'(len), 1'b0);
                    add_byte(CH_LBR, 1'b0);
                    for (int k = 0; k < len; k++)
                        add_byte(8'($urandom_range(0, 255)), 1'b0);
                    add_byte(($urandom_range(0, 1) == 0) ? CH_RBR
                                                         : 8'($urandom_range(0, 255)), 1'b0);
                    add_byte(($urandom_range(0, 1) == 0) ? cur_delim : CH_RBR, 1'b0);
                end
                7: begin
                    // huge length, often saturating; the string ends inside the field
                    if ($urandom_range(0, 3) == 0) begin
                        add_text("2147483647");
                    end else begin
                        add_byte(CH_0 + 8'($urandom_range(2, 9)), 1'b0);
                        for (int k = 1; k < MAX_DIGITS_DEF; k++)
                            add_byte(rand_digit(), 1'b0);
                    end
                    add_byte(CH_LBR, 1'b0);
                    len = $urandom_range(0, 4);
                    for (int k = 0; k < len; k++)
                        add_byte(8'($urandom_range(0, 255)), 1'b0);
                    ended = 1;
                end
                8: begin
                    // digit run longer than a prefix can be
                    len = $urandom_range(MAX_DIGITS_DEF + 1, MAX_DIGITS_DEF + 3);
                    for (int k = 0; k < len; k++)
                        add_byte(rand_digit(), 1'b0);
                    if ($urandom_range(0, 1) == 0)
                        add_byte(CH_LBR, 1'b0);
                end
                9: begin
                    // unbalanced bracket
                    add_byte(($urandom_range(0, 1) == 0) ? CH_LBR : CH_RBR, 1'b0);
                    add_byte(rand_letter(), 1'b0);
                end
                default: begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++)
                        add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            endcase
        end
        stim_q[stim_q.size()-1].fin = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one input request: random gap, then hold until accepted
    task automatic push_request(t_byte_req req);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.in_byte    = req.data;
        in_ch.final_byte = req.fin;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        chk.take_byte(req.data, req.fin);
    endtask

    task automatic send_stream();
        int sent;
        sent = 0;
        while (stim_q.size() > 0) begin
            // stretches with no input gaps now and then
            if (sent % 16 == 0)
                in_calm = ($urandom_range(0, 3) == 0);
            push_request(stim_q.pop_front());
            sent++;
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = addr;
        i_pwdata  = data;
        @(negedge i_clk);
        i_penable = 1'b1;
        do @(posedge i_clk); while (o_pready !== 1'b1);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    // every expected item in, then let a byte that caused nothing settle
    task automatic wait_quiet();
        while (chk.tokens_due.size() > 0)
            @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
    endtask

    task automatic set_delimiter(logic [7:0] value);
        apb_write(DELIM_ADDR, {24'h0, value});
        chk.delim = value;
        cur_delim = value;
    endtask

    // output side: random stalls, stall-free stretches, check on each request
    initial begin
        int gap;
        int taken;
        t_token_item got;
        out_ch.ready = 1'b0;
        out_calm = 0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 20 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
            gap = out_calm ? 0 : $urandom_range(0, 5);
            @(negedge i_clk);
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            got.out_byte  = out_ch.out_byte;
            got.token_end = out_ch.token_end;
            got.run_last  = out_ch.run_last;
            chk.match_item(got);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] phase_delims [7];
        i_rst_n          = 1'b0;
        i_psel           = 1'b0;
        i_penable        = 1'b0;
        i_pwrite         = 1'b0;
        i_paddr          = '0;
        i_pwdata         = '0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'h00;
        in_ch.final_byte = 1'b0;
        in_calm          = 0;
        cur_delim        = DELIM_RESET;
        n_phases         = 1;
        phase_delims     = '{8'h00, 8'hFF, CH_LBR, CH_RBR, 8'h35,
                             8'($urandom_range(0, 255)), DELIM_RESET};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed strings at the reset delimiter:
        // empty token then a zero-length field whose skip swallows the last byte
        add_text(",0[x");
        add_byte("y", 1'b1);
        // counted field of two, skipped closing brackets
        add_text("2[ab]");
        add_byte(CH_RBR, 1'b1);
        // saturating length, string ends as the field opens
        add_text("9999999999");
        add_byte(CH_LBR, 1'b1);
        // level wraps below zero so the delimiter stays in the token
        add_byte(CH_RBR, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(DELIM_RESET, 1'b0);
        add_byte(8'h00, 1'b1);
        send_stream();

        // random strings at the reset delimiter, then at each further setting
        for (int p = 0; p <= 7; p++) begin
            if (p > 0) begin
                wait_quiet();
                set_delimiter(phase_delims[p-1]);
                n_phases++;
            end
            while (stim_q.size() < PHASE_ITEMS)
                add_random_string();
            send_stream();
        end
        wait_quiet();

        $display("%0d bytes sent over %0d delimiter settings; %0d items received, %0d end marks",
                 chk.n_bytes, n_phases, chk.n_items, chk.n_ends);
        $display("%0d errors, %0d items still outstanding", chk.errors, chk.tokens_due.size());
        if (chk.errors == 0 && chk.tokens_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bas_pkg.sv
rtl/bas_channels.sv
rtl/bas_ctrl.sv
rtl/bas_datapath.sv
rtl/bracket_aware_splitter.sv
sim/tb_bracket_aware_splitter.sv
